// ===== sv/sre_pkg.sv =====
// ----------------------------------------------------------------------------
// sre_pkg
// Shared types, opcodes and sizes for the small RISC instruction executor.
// ----------------------------------------------------------------------------
package sre_pkg;

  // Word memory depth; a power of two, so that address wrap is a bit select.
  localparam int MEM_WORDS = 1024;
  localparam int AW        = $clog2(MEM_WORDS);
  localparam int XLEN      = 32;
  localparam int NREGS     = 8;
  localparam int REG_W     = 3;
  localparam int OP_W      = 5;
  localparam int IMM_W     = 16;
  localparam int PCO_W     = 10;
  localparam int ACT_W     = 2;
  localparam int MADDR_W   = 10;

  // instruction word field positions
  localparam int OPC_LSB = 25;
  localparam int DST_LSB = 22;
  localparam int S0_LSB  = 19;
  localparam int S1_LSB  = 16;

  // input actions
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_EXEC  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  // opcodes
  localparam logic [OP_W-1:0] OP_ADD = 5'd0;
  localparam logic [OP_W-1:0] OP_SUB = 5'd1;
  localparam logic [OP_W-1:0] OP_LSF = 5'd2;
  localparam logic [OP_W-1:0] OP_RSF = 5'd3;
  localparam logic [OP_W-1:0] OP_AND = 5'd4;
  localparam logic [OP_W-1:0] OP_OR  = 5'd5;
  localparam logic [OP_W-1:0] OP_XOR = 5'd6;
  localparam logic [OP_W-1:0] OP_LHI = 5'd7;
  localparam logic [OP_W-1:0] OP_LD  = 5'd8;
  localparam logic [OP_W-1:0] OP_ST  = 5'd9;
  localparam logic [OP_W-1:0] OP_JLT = 5'd16;
  localparam logic [OP_W-1:0] OP_JLE = 5'd17;
  localparam logic [OP_W-1:0] OP_JEQ = 5'd18;
  localparam logic [OP_W-1:0] OP_JNE = 5'd19;
  localparam logic [OP_W-1:0] OP_JIN = 5'd20;
  localparam logic [OP_W-1:0] OP_HLT = 5'd24;

  localparam logic [REG_W-1:0] REG_ZERO = 3'd0;
  localparam logic [REG_W-1:0] REG_IMM  = 3'd1;
  localparam logic [REG_W-1:0] REG_LINK = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MEM,
    ST_EXEC,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic [PCO_W-1:0] pc_value;
    logic             halted;
    logic [XLEN-1:0]  read_word;
    logic [OP_W-1:0]  opcode;
  } result_t;

  typedef struct packed {
    logic             re;
    logic [REG_W-1:0] addr_a;
    logic [REG_W-1:0] addr_b;
  } rf_rd_t;

  typedef struct packed {
    logic             we;
    logic [REG_W-1:0] addr;
    logic [XLEN-1:0]  data;
  } rf_wr_t;

endpackage

// ===== sv/sre_ram.sv =====
// ----------------------------------------------------------------------------
// sre_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module sre_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== sv/sre_regfile.sv =====
// ----------------------------------------------------------------------------
// sre_regfile
// Register file: two registered read ports, one write port. Valid bits make
// entries that were never written read as zero after reset.
// ----------------------------------------------------------------------------
module sre_regfile (
  input  logic                   clk,
  input  logic                   rst,
  input  sre_pkg::rf_rd_t        rd,
  input  sre_pkg::rf_wr_t        wr,
  output logic [sre_pkg::XLEN-1:0] rdata_a,
  output logic [sre_pkg::XLEN-1:0] rdata_b
);

  logic [sre_pkg::XLEN-1:0]  regs [sre_pkg::NREGS];
  logic [sre_pkg::NREGS-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.we) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      regs[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rdata_a <= valid[rd.addr_a] ? regs[rd.addr_a] : '0;
      rdata_b <= valid[rd.addr_b] ? regs[rd.addr_b] : '0;
    end
  end

endmodule

// ===== sv/sre_outq.sv =====
// ----------------------------------------------------------------------------
// sre_outq
// Two-entry result queue between the execution pipeline and the output port.
// ----------------------------------------------------------------------------
module sre_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sre_pkg::result_t  push_data,
  input  logic              out_ready,
  output logic              out_valid,
  output sre_pkg::result_t  out_data,
  output logic [1:0]        count
);

  sre_pkg::result_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/small_risc_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// small_risc_instruction_executor
// Executes one instruction, memory load or memory dump per input transaction.
// ----------------------------------------------------------------------------
// Write/read/idle results leave ST_MEM; execute results ST_EXEC; ld ST_LOAD.
// Throughput: write/read 1 per cycle while the result queue has room; execute
// holds off new input in instruction fetch then register file read; ld/st also
// in the data access, which shares the single memory port. Results queue in a 2-entry buffer.
// Reset: PC zero, running, registers read zero, queue empty; word memory
// contents are undefined until written.
module small_risc_instruction_executor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sre_pkg::ACT_W-1:0]   action,
  input  logic [sre_pkg::MADDR_W-1:0] mem_address,
  input  logic [sre_pkg::XLEN-1:0]    mem_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sre_pkg::PCO_W-1:0]   pc_value,
  output logic                        halted,
  output logic [sre_pkg::XLEN-1:0]    read_word,
  output logic [sre_pkg::OP_W-1:0]    executed_opcode
);

  localparam int AW   = sre_pkg::AW;
  localparam int XLEN = sre_pkg::XLEN;

  sre_pkg::state_t state, state_next;

  logic [AW-1:0]             pc, pc_next;
  logic                      running, run_next;
  logic [sre_pkg::ACT_W-1:0] it_action;
  logic                      it_exec;
  logic [XLEN-1:0]           ir;

  logic                      accept;
  logic                      accept_ok;
  logic                      room;
  logic                      pop;
  logic [2:0]                occ;

  // memory port
  logic                      m_en, m_we;
  logic [AW-1:0]             m_addr;
  logic [XLEN-1:0]           m_wdata, m_rdata;

  // register file
  sre_pkg::rf_rd_t           rf_rd;
  sre_pkg::rf_wr_t           rf_wr;
  logic [XLEN-1:0]           rf_a, rf_b;

  // result queue
  logic                      q_push;
  sre_pkg::result_t          q_data, q_out;
  logic [1:0]                q_count;

  // decode of the held instruction
  logic [sre_pkg::OP_W-1:0]  ir_op;
  logic [sre_pkg::REG_W-1:0] ir_dst, ir_s0, ir_s1, ir_asel;
  logic [XLEN-1:0]           ir_imm;
  logic [XLEN-1:0]           a_val, b_val, alu;
  logic                      jump;

  // decode of the word just fetched
  logic [sre_pkg::OP_W-1:0]  f_op;

  assign ir_op   = ir[sre_pkg::OPC_LSB +: sre_pkg::OP_W];
  assign ir_dst  = ir[sre_pkg::DST_LSB +: sre_pkg::REG_W];
  assign ir_s0   = ir[sre_pkg::S0_LSB +: sre_pkg::REG_W];
  assign ir_s1   = ir[sre_pkg::S1_LSB +: sre_pkg::REG_W];
  assign ir_imm  = {{(XLEN-sre_pkg::IMM_W){ir[sre_pkg::IMM_W-1]}},
                    ir[sre_pkg::IMM_W-1:0]};
  assign ir_asel = (ir_op == sre_pkg::OP_LHI) ? ir_dst : ir_s0;
  assign f_op    = m_rdata[sre_pkg::OPC_LSB +: sre_pkg::OP_W];

  // R0 reads zero, R1 always holds this step's immediate
  always_comb begin
    if (ir_asel == sre_pkg::REG_ZERO) begin
      a_val = '0;
    end else if (ir_asel == sre_pkg::REG_IMM) begin
      a_val = ir_imm;
    end else begin
      a_val = rf_a;
    end
    if (ir_s1 == sre_pkg::REG_ZERO) begin
      b_val = '0;
    end else if (ir_s1 == sre_pkg::REG_IMM) begin
      b_val = ir_imm;
    end else begin
      b_val = rf_b;
    end
  end

  always_comb begin
    alu  = '0;
    jump = 1'b0;
    case (ir_op)
      sre_pkg::OP_ADD: alu = a_val + b_val;
      sre_pkg::OP_SUB: alu = a_val - b_val;
      sre_pkg::OP_LSF: alu = a_val << b_val[4:0];
      sre_pkg::OP_RSF: alu = a_val >> b_val[4:0];
      sre_pkg::OP_AND: alu = a_val & b_val;
      sre_pkg::OP_OR:  alu = a_val | b_val;
      sre_pkg::OP_XOR: alu = a_val ^ b_val;
      sre_pkg::OP_LHI: alu = {ir_imm[15:0], a_val[15:0]};
      sre_pkg::OP_JLT: jump = ($signed(a_val) < $signed(b_val));
      sre_pkg::OP_JLE: jump = ($signed(a_val) <= $signed(b_val));
      sre_pkg::OP_JEQ: jump = (a_val == b_val);
      sre_pkg::OP_JNE: jump = (a_val != b_val);
      sre_pkg::OP_JIN: jump = 1'b1;
      default: begin
        alu  = '0;
        jump = 1'b0;
      end
    endcase
  end

  assign pop    = out_valid && out_ready;
  assign occ    = {1'b0, q_count} + {2'b00, (state != sre_pkg::ST_IDLE)};
  assign room   = (occ <= 3'd1) || ((occ == 3'd2) && pop);
  assign in_ready = accept_ok && room;
  assign accept = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sre_pkg::ST_IDLE: begin
        state_next = accept ? sre_pkg::ST_MEM : sre_pkg::ST_IDLE;
      end
      sre_pkg::ST_MEM: begin
        if (it_exec) begin
          state_next = sre_pkg::ST_EXEC;
        end else begin
          state_next = accept ? sre_pkg::ST_MEM : sre_pkg::ST_IDLE;
        end
      end
      sre_pkg::ST_EXEC: begin
        if (ir_op == sre_pkg::OP_LD) begin
          state_next = sre_pkg::ST_LOAD;
        end else begin
          state_next = accept ? sre_pkg::ST_MEM : sre_pkg::ST_IDLE;
        end
      end
      sre_pkg::ST_LOAD: begin
        state_next = accept ? sre_pkg::ST_MEM : sre_pkg::ST_IDLE;
      end
      default: state_next = sre_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    accept_ok = 1'b0;
    pc_next   = pc;
    run_next  = running;
    q_push    = 1'b0;
    q_data    = '{pc_value: sre_pkg::PCO_W'(pc), halted: !running,
                  read_word: '0, opcode: '0};
    rf_rd     = '{re: 1'b0, addr_a: '0, addr_b: '0};
    rf_wr     = '{we: 1'b0, addr: '0, data: '0};
    case (state)
      sre_pkg::ST_IDLE: begin
        accept_ok = 1'b1;
      end
      sre_pkg::ST_MEM: begin
        accept_ok = !it_exec;
        if (it_exec) begin
          rf_rd.re     = 1'b1;
          rf_rd.addr_a = (f_op == sre_pkg::OP_LHI)
                         ? m_rdata[sre_pkg::DST_LSB +: sre_pkg::REG_W]
                         : m_rdata[sre_pkg::S0_LSB +: sre_pkg::REG_W];
          rf_rd.addr_b = m_rdata[sre_pkg::S1_LSB +: sre_pkg::REG_W];
        end else begin
          q_push = 1'b1;
          if (it_action == sre_pkg::ACT_READ) begin
            q_data.read_word = m_rdata;
          end
        end
      end
      sre_pkg::ST_EXEC: begin
        accept_ok = (ir_op != sre_pkg::OP_LD) && (ir_op != sre_pkg::OP_ST);
        pc_next   = jump ? ir_imm[AW-1:0] : pc + AW'(1);
        if (ir_op == sre_pkg::OP_HLT) begin
          run_next = 1'b0;
        end
        if (jump) begin
          rf_wr = '{we: 1'b1, addr: sre_pkg::REG_LINK, data: XLEN'(pc)};
        end else if (ir_op <= sre_pkg::OP_LHI) begin
          // writes to R0 and R1 are dropped: R1 is reloaded every step
          rf_wr = '{we: (ir_dst > sre_pkg::REG_IMM), addr: ir_dst, data: alu};
        end
        if (ir_op != sre_pkg::OP_LD) begin
          q_push = 1'b1;
          q_data = '{pc_value: sre_pkg::PCO_W'(pc_next), halted: !run_next,
                     read_word: '0, opcode: ir_op};
        end
      end
      sre_pkg::ST_LOAD: begin
        accept_ok = 1'b1;
        rf_wr     = '{we: (ir_dst > sre_pkg::REG_IMM), addr: ir_dst, data: m_rdata};
        q_push    = 1'b1;
        q_data.opcode = sre_pkg::OP_LD;
      end
      default: accept_ok = 1'b0;
    endcase
  end

  // memory port: data access of ld/st, else the access of a new transaction
  always_comb begin
    m_en    = 1'b0;
    m_we    = 1'b0;
    m_addr  = '0;
    m_wdata = mem_data;
    if ((state == sre_pkg::ST_EXEC) &&
        ((ir_op == sre_pkg::OP_LD) || (ir_op == sre_pkg::OP_ST))) begin
      m_en    = 1'b1;
      m_we    = (ir_op == sre_pkg::OP_ST);
      m_addr  = b_val[AW-1:0];
      m_wdata = a_val;
    end else if (accept) begin
      case (action)
        sre_pkg::ACT_WRITE: begin
          m_en   = 1'b1;
          m_we   = 1'b1;
          m_addr = AW'(mem_address);
        end
        sre_pkg::ACT_READ: begin
          m_en   = 1'b1;
          m_addr = AW'(mem_address);
        end
        sre_pkg::ACT_EXEC: begin
          m_en   = run_next;
          m_addr = pc_next;
        end
        default: m_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sre_pkg::ST_IDLE;
      pc        <= '0;
      running   <= 1'b1;
      it_exec   <= 1'b0;
      it_action <= sre_pkg::ACT_WRITE;
    end else begin
      state   <= state_next;
      pc      <= pc_next;
      running <= run_next;
      if (accept) begin
        it_action <= action;
        it_exec   <= (action == sre_pkg::ACT_EXEC) && run_next;
      end
    end
  end

  // hold the fetched instruction through execute and load
  always_ff @(posedge clk) begin
    if ((state == sre_pkg::ST_MEM) && it_exec) begin
      ir <= m_rdata;
    end
  end

  sre_ram #(
    .DEPTH (sre_pkg::MEM_WORDS),
    .WIDTH (XLEN)
  ) u_mem (
    .clk   (clk),
    .en    (m_en),
    .we    (m_we),
    .addr  (m_addr),
    .wdata (m_wdata),
    .rdata (m_rdata)
  );

  sre_regfile u_rf (
    .clk     (clk),
    .rst     (rst),
    .rd      (rf_rd),
    .wr      (rf_wr),
    .rdata_a (rf_a),
    .rdata_b (rf_b)
  );

  sre_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (q_out),
    .count     (q_count)
  );

  assign pc_value        = q_out.pc_value;
  assign halted          = q_out.halted;
  assign read_word       = q_out.read_word;
  assign executed_opcode = q_out.opcode;

  // result queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> ((q_count < 2'd2) || pop))
    else $error("result queue overflow");

  // register file read and write never share an edge
  a_rf_excl: assert property (@(posedge clk) disable iff (rst)
    !(rf_rd.re && rf_wr.we))
    else $error("register file read and write in same cycle");

  // only reset restarts a halted processor
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    !$rose(running))
    else $error("running flag set without reset");

  // data access of ld/st never collides with a new transaction
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    ((state == sre_pkg::ST_EXEC) &&
     ((ir_op == sre_pkg::OP_LD) || (ir_op == sre_pkg::OP_ST))) |-> !accept)
    else $error("memory port conflict");

endmodule

// ===== tb/sre_result_check.sv =====
// ----------------------------------------------------------------------------
// sre_result_check
// Watches both channels of the instruction executor, keeps its own copy of
// the processor (registers, word memory, PC, run flag), predicts the result
// of every accepted input transaction and compares each output transaction
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sre_result_check
  import sre_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [ACT_W-1:0]   action,
  input  logic [MADDR_W-1:0] mem_address,
  input  logic [XLEN-1:0]    mem_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [PCO_W-1:0]   pc_value,
  input  logic               halted,
  input  logic [XLEN-1:0]    read_word,
  input  logic [OP_W-1:0]    executed_opcode,
  output int                 fail_count = 0,
  output int                 pending_count = 0,
  output logic [AW-1:0]      pc_after = '0
);

  logic [XLEN-1:0] cpu_regs [NREGS];
  logic [XLEN-1:0] cpu_mem  [MEM_WORDS];
  logic [AW-1:0]   cpu_pc;
  logic            cpu_running;

  result_t awaited_results [$];

  function automatic logic [XLEN-1:0] get_reg(input logic [REG_W-1:0] n);
    return (n == REG_ZERO) ? '0 : cpu_regs[n];
  endfunction

  task automatic put_reg(input logic [REG_W-1:0] n, input logic [XLEN-1:0] v);
    if (n != REG_ZERO) cpu_regs[n] = v;
  endtask

  task automatic run_instruction(output logic [OP_W-1:0] op);
    logic [XLEN-1:0]  word;
    logic [XLEN-1:0]  imm;
    logic [XLEN-1:0]  a;
    logic [XLEN-1:0]  b;
    logic [REG_W-1:0] d;
    logic [REG_W-1:0] s0;
    logic [REG_W-1:0] s1;
    logic             take;
    word = cpu_mem[cpu_pc];
    op   = word[OPC_LSB +: OP_W];
    d    = word[DST_LSB +: REG_W];
    s0   = word[S0_LSB +: REG_W];
    s1   = word[S1_LSB +: REG_W];
    imm  = {{(XLEN-IMM_W){word[IMM_W-1]}}, word[IMM_W-1:0]};
    // the immediate lands in R1 before operands are read
    put_reg(REG_IMM, imm);
    a    = get_reg(s0);
    b    = get_reg(s1);
    take = 1'b0;
    case (op)
      OP_ADD: put_reg(d, a + b);
      OP_SUB: put_reg(d, a - b);
      OP_LSF: put_reg(d, a << b[4:0]);
      OP_RSF: put_reg(d, a >> b[4:0]);
      OP_AND: put_reg(d, a & b);
      OP_OR:  put_reg(d, a | b);
      OP_XOR: put_reg(d, a ^ b);
      OP_LHI: put_reg(d, (get_reg(d) & {{(XLEN-IMM_W){1'b0}}, {IMM_W{1'b1}}}) |
                         (get_reg(REG_IMM) << IMM_W));
      OP_LD:  put_reg(d, cpu_mem[b % MEM_WORDS]);
      OP_ST:  cpu_mem[b % MEM_WORDS] = a;
      OP_JLT: take = $signed(a) < $signed(b);
      OP_JLE: take = $signed(a) <= $signed(b);
      OP_JEQ: take = (a == b);
      OP_JNE: take = (a != b);
      OP_JIN: take = 1'b1;
      OP_HLT: cpu_running = 1'b0;
      default: ;
    endcase
    if (take) begin
      put_reg(REG_LINK, XLEN'(cpu_pc));
      cpu_pc = AW'(get_reg(REG_IMM) % MEM_WORDS);
    end else begin
      cpu_pc = cpu_pc + 1'b1;
    end
  endtask

  task automatic predict_item(input logic [ACT_W-1:0] act, input logic [MADDR_W-1:0] addr,
                              input logic [XLEN-1:0] data, output result_t res);
    logic [XLEN-1:0] rword;
    logic [OP_W-1:0] op;
    rword = '0;
    op    = '0;
    case (act)
      ACT_WRITE: cpu_mem[addr % MEM_WORDS] = data;
      ACT_EXEC:  if (cpu_running) run_instruction(op);
      ACT_READ:  rword = cpu_mem[addr % MEM_WORDS];
      default: ;
    endcase
    res.pc_value  = PCO_W'(cpu_pc);
    res.halted    = !cpu_running;
    res.read_word = rword;
    res.opcode    = op;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    int      errs;
    errs = 0;
    if (rst) begin
      for (int i = 0; i < NREGS; i++) cpu_regs[i] = '0;
      cpu_pc      = '0;
      cpu_running = 1'b1;
      awaited_results.delete();
      pc_after      <= '0;
      pending_count <= 0;
    end else begin
      // check results first: a result can never belong to this edge's input
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result with no transaction pending: pc_value %0d", pc_value);
          errs++;
        end else begin
          want = awaited_results.pop_front();
          if (pc_value !== want.pc_value) begin
            $error("pc_value: expected %0d, got %0d", want.pc_value, pc_value);
            errs++;
          end
          if (halted !== want.halted) begin
            $error("halted: expected %0d, got %0d", want.halted, halted);
            errs++;
          end
          if (read_word !== want.read_word) begin
            $error("read_word: expected %08h, got %08h", want.read_word, read_word);
            errs++;
          end
          if (executed_opcode !== want.opcode) begin
            $error("executed_opcode: expected %0d, got %0d", want.opcode, executed_opcode);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_item(action, mem_address, mem_data, want);
        awaited_results.push_back(want);
      end
      pc_after      <= cpu_pc;
      pending_count <= awaited_results.size();
    end
    if (errs != 0) fail_count <= fail_count + errs;
  end

endmodule

// ===== tb/small_risc_instruction_executor_test.sv =====
// ----------------------------------------------------------------------------
// small_risc_instruction_executor_test
// Loads the whole word memory with a boot program and random words, runs a
// directed walk through every operation but halt, then random load/execute/dump
// traffic with random idling on both channels and one long output stall.
// Each instruction is written at the current PC just before it executes, so
// halting happens only at the end. A checker beside the block predicts and
// compares; this module drives the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module small_risc_instruction_executor_test;
  import sre_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS    = 700;
  localparam int PRESSURE_AT     = 300;
  localparam int PRESSURE_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 16;
  localparam int TIMEOUT_NS      = 6_000_000;

  logic               clk;
  logic               rst             = 1'b1;
  logic               in_valid        = 1'b0;
  logic               in_ready;
  logic [ACT_W-1:0]   action          = '0;
  logic [MADDR_W-1:0] mem_address     = '0;
  logic [XLEN-1:0]    mem_data        = '0;
  logic               out_valid;
  logic               out_ready       = 1'b0;
  logic [PCO_W-1:0]   pc_value;
  logic               halted;
  logic [XLEN-1:0]    read_word;
  logic [OP_W-1:0]    executed_opcode;

  int                 fail_count;
  int                 pending_count;
  logic [AW-1:0]      pc_after;

  logic               pressure_req    = 1'b0;
  int                 items_sent      = 0;
  int                 burst_left      = 0;

  small_risc_instruction_executor DUT (.*);

  sre_result_check u_check (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [XLEN-1:0] encode(input logic [OP_W-1:0] op,
                                             input logic [REG_W-1:0] d,
                                             input logic [REG_W-1:0] s0,
                                             input logic [REG_W-1:0] s1,
                                             input logic [IMM_W-1:0] imm);
    return {2'b00, op, d, s0, s1, imm};
  endfunction

  // boot image: a walk through every operation but halt, random words elsewhere
  function automatic logic [XLEN-1:0] boot_word(input int addr);
    case (addr)
      0:  return encode(OP_ADD, 3'd2, REG_IMM, REG_ZERO, 16'h7FFF);
      1:  return encode(OP_LHI, 3'd2, REG_ZERO, REG_ZERO, 16'h8000);
      2:  return encode(OP_SUB, 3'd3, REG_ZERO, REG_IMM, 16'h0001);
      3:  return encode(OP_LSF, 3'd4, 3'd3, REG_IMM, 16'd31);
      // shift amount comes from the low five bits only
      4:  return encode(OP_RSF, 3'd5, 3'd3, REG_IMM, 16'hFFE1);
      5:  return encode(OP_AND, 3'd6, 3'd2, 3'd3, 16'h0000);
      // result aimed at R0 must vanish
      6:  return encode(OP_OR,  REG_ZERO, 3'd2, 3'd3, 16'h1234);
      7:  return encode(OP_XOR, 3'd6, 3'd6, REG_IMM, 16'hFFFF);
      // address of all ones wraps to the top word
      8:  return encode(OP_ST,  REG_ZERO, 3'd4, REG_IMM, 16'hFFFF);
      9:  return encode(OP_LD,  3'd2, REG_ZERO, REG_IMM, 16'h03FF);
      10: return encode(OP_JLT, REG_ZERO, 3'd4, 3'd5, 16'd12);
      12: return encode(OP_JLE, REG_ZERO, 3'd5, 3'd4, 16'h0020);
      // target beyond memory wraps back to word 16
      13: return encode(OP_JEQ, REG_ZERO, 3'd3, 3'd3, 16'h0410);
      16: return encode(OP_JNE, REG_ZERO, REG_ZERO, REG_ZERO, 16'h0040);
      17: return encode(OP_JLE, REG_ZERO, 3'd3, 3'd3, 16'd19);
      // unknown opcode with every field at ones
      19: return '1;
      // jump to the last word; the stored word there runs, then the PC wraps
      20: return encode(OP_JIN, REG_ZERO, REG_ZERO, REG_ZERO, 16'hFFFF);
      default: return $urandom;
    endcase
  endfunction

  // never a halt: that is kept for the very end
  function automatic logic [XLEN-1:0] rand_instr();
    logic [OP_W-1:0]  op;
    logic [IMM_W-1:0] imm;
    logic [XLEN-1:0]  word;
    if ($urandom_range(0, 15) == 0) begin
      do op = OP_W'($urandom);
      while (op <= OP_ST || (op >= OP_JLT && op <= OP_JIN) || op == OP_HLT);
    end else begin
      case ($urandom_range(0, 14))
        0:  op = OP_ADD;
        1:  op = OP_SUB;
        2:  op = OP_LSF;
        3:  op = OP_RSF;
        4:  op = OP_AND;
        5:  op = OP_OR;
        6:  op = OP_XOR;
        7:  op = OP_LHI;
        8:  op = OP_LD;
        9:  op = OP_ST;
        10: op = OP_JLT;
        11: op = OP_JLE;
        12: op = OP_JEQ;
        13: op = OP_JNE;
        default: op = OP_JIN;
      endcase
    end
    case ($urandom_range(0, 3))
      0: imm = IMM_W'($urandom_range(0, 40));
      1: begin
        case ($urandom_range(0, 3))
          0: imm = '0;
          1: imm = 16'h7FFF;
          2: imm = 16'h8000;
          default: imm = '1;
        endcase
      end
      default: imm = IMM_W'($urandom);
    endcase
    word = encode(op, REG_W'($urandom), REG_W'($urandom), REG_W'($urandom), imm);
    // bits above the opcode are don't-care
    word[XLEN-1 -: 2] = 2'($urandom);
    return word;
  endfunction

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [MADDR_W-1:0] addr,
                           input logic [XLEN-1:0] data);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 31) == 0) burst_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    mem_address <= addr;
    mem_data    <= data;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // load word at the current PC, then execute it
  task automatic exec_instr(input logic [XLEN-1:0] word, input bit read_between);
    int pick;
    pick = $urandom_range(0, 9);
    // one unrelated transaction first, so pc_after has caught up
    if (pick < 6) send_item(ACT_READ, MADDR_W'($urandom), $urandom);
    else if (pick < 9) send_item(ACT_WRITE, MADDR_W'($urandom), $urandom);
    else send_item(ACT_UNUSED, MADDR_W'($urandom), $urandom);
    send_item(ACT_WRITE, MADDR_W'(pc_after), word);
    if (read_between) send_item(ACT_READ, MADDR_W'($urandom), $urandom);
    send_item(ACT_EXEC, MADDR_W'($urandom), $urandom);
  endtask

  // output side: random stalls plus one long hold-off on request
  initial begin : result_sink
    int stall_left;
    int ready_left;
    bit pressure_done;
    stall_left    = 0;
    ready_left    = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (pressure_req && !pressure_done) begin
        // hold long enough that the block backs up into its input
        out_ready     <= 1'b0;
        pressure_done = 1'b1;
        stall_left    = PRESSURE_CYCLES - 1;
      end else if (ready_left > 0) begin
        out_ready <= 1'b1;
        ready_left--;
      end else begin
        out_ready  <= 1'b1;
        ready_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(0, 10);
        stall_left = idle_len();
      end
    end
  end

  initial begin : stimulus
    int random_end;
    int pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // program load: every word gets written, so no read ever sees an empty word
    for (int a = 0; a < MEM_WORDS; a++) send_item(ACT_WRITE, MADDR_W'(a), boot_word(a));

    // directed walk through the boot program
    repeat (18) send_item(ACT_EXEC, MADDR_W'($urandom), $urandom);
    send_item(ACT_READ, MADDR_W'(MEM_WORDS - 1), $urandom);
    send_item(ACT_UNUSED, '1, '1);
    send_item(ACT_WRITE, '1, '1);
    send_item(ACT_READ, '0, '0);

    random_end = items_sent + RANDOM_ITEMS;
    while (items_sent < random_end) begin
      if (!pressure_req && items_sent >= random_end - RANDOM_ITEMS + PRESSURE_AT)
        pressure_req <= 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 70) exec_instr(rand_instr(), 1'b0);
      else if (pick < 75) exec_instr(rand_instr(), 1'b1);
      else if (pick < 85) send_item(ACT_READ, MADDR_W'($urandom), $urandom);
      else if (pick < 92) send_item(ACT_WRITE, MADDR_W'($urandom), $urandom);
      else if (pick < 96) send_item(ACT_UNUSED, MADDR_W'($urandom), $urandom);
      else send_item(ACT_WRITE, MADDR_W'(pc_after), rand_instr());
    end

    // halt, then poke the stopped machine
    exec_instr(encode(OP_HLT, REG_W'($urandom), REG_W'($urandom), REG_W'($urandom),
                      IMM_W'($urandom)), 1'b0);
    repeat (3) send_item(ACT_EXEC, MADDR_W'($urandom), $urandom);
    send_item(ACT_READ, MADDR_W'($urandom), $urandom);
    send_item(ACT_WRITE, MADDR_W'($urandom), $urandom);
    send_item(ACT_UNUSED, MADDR_W'($urandom), $urandom);
    send_item(ACT_EXEC, MADDR_W'($urandom), $urandom);
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sre_pkg.sv
sv/sre_ram.sv
sv/sre_regfile.sv
sv/sre_outq.sv
sv/small_risc_instruction_executor.sv
tb/sre_result_check.sv
tb/small_risc_instruction_executor_test.sv
